// File: hw/rtl/tmc_pkg.sv
// Shared types, constants and rounding helper for the tilt midpoint calibrator.
package tmc_pkg;

  // Unusable samples in a row that drop the current candidate.
  localparam logic [2:0] INVALID_LIMIT = 3'd5;

  // Classified-item queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CFG_FILTER_ALPHA   = 3'd0,
    CFG_UPRIGHT_WINDOW = 3'd1,
    CFG_GYRO_MAX       = 3'd2,
    CFG_ACCEL_MIN_SQ   = 3'd3,
    CFG_ACCEL_MAX_SQ   = 3'd4,
    CFG_MAX_SPAN       = 3'd5,
    CFG_MAX_ERROR      = 3'd6,
    CFG_STABLE_TARGET  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] filter_alpha;
    logic [14:0] upright_window;
    logic [15:0] gyro_max;
    logic [31:0] accel_min_sq;
    logic [31:0] accel_max_sq;
    logic [15:0] max_span;
    logic [15:0] max_error;
    logic [15:0] stable_target;
  } cfg_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic               func;
    logic signed [15:0] pitch;
    logic               sample_ok;
  } item_t;

  // Q16.16 to whole units, halves away from zero, saturated to 16 bits.
  function automatic logic signed [15:0] to_angle(input logic signed [31:0] q);
    logic signed [32:0] biased;
    logic signed [16:0] r;
    biased = $signed({q[31], q}) + (q[31] ? 33'sd32767 : 33'sd32768);
    r      = biased[32:16];
    if (r > 17'sd32767) begin
      to_angle = 16'sh7fff;
    end else if (r < -17'sd32768) begin
      to_angle = 16'sh8000;
    end else begin
      to_angle = r[15:0];
    end
  endfunction

endpackage

// File: hw/rtl/tmc_front.sv
// Front part: accepts items, squares the accelerometer axes and classifies the sample.
module tmc_front
  import tmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [15:0] in_pitch,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [QUEUE_AW:0]  q_count,
  output logic               push,
  output item_t              push_item
);

  logic               s1_valid_r;
  logic               s1_func_r;
  logic signed [15:0] s1_pitch_r;
  logic               s1_pitch_ok_r;
  logic               s1_gyro_ok_r;
  logic [30:0]        s1_sqx_r;
  logic [30:0]        s1_sqy_r;
  logic [30:0]        s1_sqz_r;

  logic signed [16:0] pitch_ext;
  logic signed [16:0] gyro_ext;
  logic [16:0]        pitch_mag;
  logic [16:0]        gyro_mag;
  logic signed [31:0] sqx;
  logic signed [31:0] sqy;
  logic signed [31:0] sqz;
  logic [31:0]        sq_sum;
  logic [QUEUE_AW:0]  occupancy;
  logic               accept;

  // The stage register counts against the queue, so it never has to hold.
  assign occupancy = q_count + (QUEUE_AW + 1)'(s1_valid_r);
  assign in_stall  = occupancy >= (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  assign pitch_ext = {in_pitch[15], in_pitch};
  assign gyro_ext  = {in_gyro_y[15], in_gyro_y};
  assign pitch_mag = pitch_ext[16] ? 17'(-pitch_ext) : 17'(pitch_ext);
  assign gyro_mag  = gyro_ext[16] ? 17'(-gyro_ext) : 17'(gyro_ext);

  assign sqx = in_accel_x * in_accel_x;
  assign sqy = in_accel_y * in_accel_y;
  assign sqz = in_accel_z * in_accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r     <= in_func;
      s1_pitch_r    <= in_pitch;
      s1_pitch_ok_r <= pitch_mag <= {2'b00, cfg.upright_window};
      s1_gyro_ok_r  <= gyro_mag <= {1'b0, cfg.gyro_max};
      s1_sqx_r      <= sqx[30:0];
      s1_sqy_r      <= sqy[30:0];
      s1_sqz_r      <= sqz[30:0];
    end
  end

  // Three squares of at most 2^30 each still fit in 32 bits.
  assign sq_sum = 32'(s1_sqx_r) + 32'(s1_sqy_r) + 32'(s1_sqz_r);

  assign push                = s1_valid_r;
  assign push_item.func      = s1_func_r;
  assign push_item.pitch     = s1_pitch_r;
  assign push_item.sample_ok = s1_pitch_ok_r && s1_gyro_ok_r &&
                               (sq_sum >= cfg.accel_min_sq) &&
                               (sq_sum <= cfg.accel_max_sq);

endmodule

// File: hw/rtl/tmc_queue.sv
// Short queue of classified items between the front and back parts.
module tmc_queue
  import tmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output item_t             head,
  output logic              not_empty,
  output logic [QUEUE_AW:0] count
);

  item_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head      = entry_r[rd_ptr_r];
  assign not_empty = count_r != '0;
  assign count     = count_r;

endmodule

// File: hw/rtl/tmc_back.sv
// Back part: candidate state, low-pass filter update and the result register.
module tmc_back
  import tmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  item_t              head,
  input  logic               q_not_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ready_res,
  output logic               out_just_completed,
  output logic signed [15:0] out_midpoint,
  output logic signed [15:0] out_filtered_angle,
  output logic [15:0]        out_stable_count,
  output logic               out_sample_valid
);

  // Candidate state. It doubles as the result register, since it only moves
  // when the previous result has been taken.
  logic signed [31:0] filter_r,   filter_nxt;
  logic               started_r,  started_nxt;
  logic [15:0]        stable_r,   stable_nxt;
  logic [2:0]         invalid_r,  invalid_nxt;
  logic signed [15:0] win_low_r,  win_low_nxt;
  logic signed [15:0] win_high_r, win_high_nxt;
  logic               ready_r,    ready_nxt;
  logic signed [31:0] latched_r,  latched_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               done_r,     done_nxt;
  logic               svalid_r,   svalid_nxt;

  logic signed [32:0] pitch_q;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] prod_biased;
  logic signed [33:0] filter_step;
  logic signed [34:0] new_filter;
  logic signed [35:0] err;
  logic [35:0]        err_mag;
  logic signed [15:0] low_cand;
  logic signed [15:0] high_cand;
  logic [16:0]        span;
  logic [15:0]        stable_inc;
  logic [2:0]         invalid_inc;

  assign pop = q_not_empty && (!out_valid_r || !out_stall);

  // Filter step, rounded to nearest with halves away from zero.
  assign pitch_q     = $signed({head.pitch[15], head.pitch, 16'h0000});
  assign diff        = pitch_q - $signed({filter_r[31], filter_r});
  assign prod        = diff * $signed({1'b0, cfg.filter_alpha});
  assign prod_biased = prod + (prod[49] ? 50'sd32767 : 50'sd32768);
  assign filter_step = prod_biased[49:16];
  assign new_filter  = $signed({{3{filter_r[31]}}, filter_r}) +
                       $signed({filter_step[33], filter_step});
  assign err         = $signed({{3{pitch_q[32]}}, pitch_q}) -
                       $signed({new_filter[34], new_filter});
  assign err_mag     = err[35] ? 36'(-err) : 36'(err);

  assign low_cand  = (head.pitch < win_low_r) ? head.pitch : win_low_r;
  assign high_cand = (head.pitch > win_high_r) ? head.pitch : win_high_r;
  assign span      = 17'($signed({high_cand[15], high_cand}) -
                         $signed({low_cand[15], low_cand}));

  assign stable_inc  = (stable_r < cfg.stable_target) ? stable_r + 16'd1 : stable_r;
  assign invalid_inc = (invalid_r < INVALID_LIMIT) ? invalid_r + 3'd1 : invalid_r;

  always_comb begin
    filter_nxt   = filter_r;
    started_nxt  = started_r;
    stable_nxt   = stable_r;
    invalid_nxt  = invalid_r;
    win_low_nxt  = win_low_r;
    win_high_nxt = win_high_r;
    ready_nxt    = ready_r;
    latched_nxt  = latched_r;
    done_nxt     = done_r;
    svalid_nxt   = svalid_r;

    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    if (pop) begin
      done_nxt   = 1'b0;
      svalid_nxt = !head.func && head.sample_ok;
      if (head.func) begin
        filter_nxt   = '0;
        started_nxt  = 1'b0;
        stable_nxt   = '0;
        invalid_nxt  = '0;
        win_low_nxt  = '0;
        win_high_nxt = '0;
        ready_nxt    = 1'b0;
        latched_nxt  = '0;
      end else if (!ready_r) begin
        if (!head.sample_ok) begin
          if (invalid_inc >= INVALID_LIMIT) begin
            filter_nxt   = '0;
            started_nxt  = 1'b0;
            stable_nxt   = '0;
            invalid_nxt  = '0;
            win_low_nxt  = '0;
            win_high_nxt = '0;
          end else begin
            invalid_nxt = invalid_inc;
          end
        end else if (!started_r) begin
          invalid_nxt  = '0;
          filter_nxt   = pitch_q[31:0];
          stable_nxt   = 16'd1;
          started_nxt  = 1'b1;
          win_low_nxt  = head.pitch;
          win_high_nxt = head.pitch;
        end else if ((span > {1'b0, cfg.max_span}) ||
                     (err_mag > {4'h0, cfg.max_error, 16'h0000})) begin
          filter_nxt   = '0;
          started_nxt  = 1'b0;
          stable_nxt   = '0;
          invalid_nxt  = '0;
          win_low_nxt  = '0;
          win_high_nxt = '0;
        end else begin
          invalid_nxt  = '0;
          win_low_nxt  = low_cand;
          win_high_nxt = high_cand;
          filter_nxt   = new_filter[31:0];
          stable_nxt   = stable_inc;
          if (stable_inc >= cfg.stable_target) begin
            latched_nxt = new_filter[31:0];
            ready_nxt   = 1'b1;
            done_nxt    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r    <= '0;
      started_r   <= 1'b0;
      stable_r    <= '0;
      invalid_r   <= '0;
      win_low_r   <= '0;
      win_high_r  <= '0;
      ready_r     <= 1'b0;
      latched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      filter_r    <= filter_nxt;
      started_r   <= started_nxt;
      stable_r    <= stable_nxt;
      invalid_r   <= invalid_nxt;
      win_low_r   <= win_low_nxt;
      win_high_r  <= win_high_nxt;
      ready_r     <= ready_nxt;
      latched_r   <= latched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_r   <= done_nxt;
    svalid_r <= svalid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ready_res      = ready_r;
  assign out_just_completed = done_r;
  assign out_midpoint       = to_angle(latched_r);
  assign out_filtered_angle = to_angle(filter_r);
  assign out_stable_count   = stable_r;
  assign out_sample_valid   = svalid_r;

endmodule

// File: hw/rtl/tilt_midpoint_calibrator_core.sv
// Top level of the tilt midpoint calibrator: configuration registers and the three parts.
// One result comes out for every item, and a new item is taken every clock cycle
// in steady flow while the output is not stalled; a result is shown once its item
// has passed the classification register, the queue and the state update. The
// rate is set by the back part, which updates the filter once per cycle while the
// output is not stalled, with a single 33 by 17 bit multiplier. The four-entry queue
// lets the input keep flowing while a result waits on a stalled output. A restart
// item clears all candidate and latched state.
module tilt_midpoint_calibrator_core
  import tmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [15:0] in_pitch,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ready_res,
  output logic               out_just_completed,
  output logic signed [15:0] out_midpoint,
  output logic signed [15:0] out_filtered_angle,
  output logic [15:0]        out_stable_count,
  output logic               out_sample_valid
);

  cfg_t              cfg_r;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             head;
  logic              q_not_empty;
  logic [QUEUE_AW:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_alpha   <= 16'd2621;
      cfg_r.upright_window <= 15'd1536;
      cfg_r.gyro_max       <= 16'd32;
      cfg_r.accel_min_sq   <= 32'd193944617;
      cfg_r.accel_max_sq   <= 32'd355005890;
      cfg_r.max_span       <= 16'd102;
      cfg_r.max_error      <= 16'd77;
      cfg_r.stable_target  <= 16'd300;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_ALPHA:   cfg_r.filter_alpha   <= cfg_wdata[15:0];
        CFG_UPRIGHT_WINDOW: cfg_r.upright_window <= cfg_wdata[14:0];
        CFG_GYRO_MAX:       cfg_r.gyro_max       <= cfg_wdata[15:0];
        CFG_ACCEL_MIN_SQ:   cfg_r.accel_min_sq   <= cfg_wdata;
        CFG_ACCEL_MAX_SQ:   cfg_r.accel_max_sq   <= cfg_wdata;
        CFG_MAX_SPAN:       cfg_r.max_span       <= cfg_wdata[15:0];
        CFG_MAX_ERROR:      cfg_r.max_error      <= cfg_wdata[15:0];
        CFG_STABLE_TARGET:  cfg_r.stable_target  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  tmc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_pitch   (in_pitch),
    .in_gyro_y  (in_gyro_y),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .q_count    (q_count),
    .push       (push),
    .push_item  (push_item)
  );

  tmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  tmc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head               (head),
    .q_not_empty        (q_not_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ready_res      (out_ready_res),
    .out_just_completed (out_just_completed),
    .out_midpoint       (out_midpoint),
    .out_filtered_angle (out_filtered_angle),
    .out_stable_count   (out_stable_count),
    .out_sample_valid   (out_sample_valid)
  );

endmodule

// File: hw/rtl/tmc_checker.sv
// Port-level assertions for the tilt midpoint calibrator, bound to the top level.
module tmc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_ready_res,
  input logic               out_just_completed,
  input logic signed [15:0] out_midpoint,
  input logic signed [15:0] out_filtered_angle,
  input logic [15:0]        out_stable_count
);

  // No result may appear in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A held result keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_midpoint) &&
      $stable(out_filtered_angle) && $stable(out_stable_count))
    else $error("stalled result changed");

  // Completion is only ever reported together with the ready flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_just_completed |-> out_ready_res)
    else $error("completion without ready flag");

  // Before the midpoint is latched it reads as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready_res |-> out_midpoint == 16'sd0)
    else $error("midpoint shown before it was latched");

  // With no stable samples there is no candidate, so the filter is cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stable_count == 16'd0 |-> out_filtered_angle == 16'sd0)
    else $error("filter value left over without a candidate");

endmodule

bind tilt_midpoint_calibrator_core tmc_checker u_tmc_checker (.*);

// File: bench/tilt_midpoint_calibrator_core_tb.sv
// Self-checking testbench for the tilt midpoint calibrator core, with its own predictor.
`timescale 1ns / 1ps

module tilt_midpoint_calibrator_core_tb;
  import tmc_pkg::*;

  typedef struct {
    logic               func;
    logic signed [15:0] pitch;
    logic signed [15:0] gyro_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct {
    logic               ready;
    logic               done;
    logic signed [15:0] midpoint;
    logic signed [15:0] angle;
    logic [15:0]        count;
    logic               usable;
  } calib_result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS [6] = '{300, 250, 120, 300, 450, 480};

  localparam cfg_t RESET_CFG = '{
    filter_alpha: 16'd2621, upright_window: 15'd1536, gyro_max: 16'd32,
    accel_min_sq: 32'd193944617, accel_max_sq: 32'd355005890,
    max_span: 16'd102, max_error: 16'd77, stable_target: 16'd300};

  // Holds the calibrator state as the block should see it and the expected results
  // that are still to come out.
  class calib_scoreboard;
    cfg_t               regs;
    int                 filt;
    bit                 started;
    bit                 ready;
    logic [15:0]        count;
    logic [2:0]         bad_run;
    int                 win_lo;
    int                 win_hi;
    logic signed [15:0] mid;
    calib_result_t      expected_q[$];
    int                 mismatches;
    int                 checked;

    function void load_config(cfg_t c);
      regs = c;
    endfunction

    function void drop_candidate();
      filt    = 0;
      started = 0;
      count   = '0;
      bad_run = '0;
      win_lo  = 0;
      win_hi  = 0;
    endfunction

    function void clear_all();
      drop_candidate();
      ready = 0;
      mid   = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Divide by 65536, rounding to nearest with halves away from zero.
    function longint div_round(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + 32768) >>> 16;
      return (v < 0) ? -m : m;
    endfunction

    function logic signed [15:0] angle_of(int q);
      longint r;
      r = div_round(longint'(q));
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
    endfunction

    function bit usable(sample_t s);
      int     ap;
      int     ag;
      longint sq;
      ap = int'(s.pitch);
      ag = int'(s.gyro_y);
      if (ap < 0) ap = -ap;
      if (ag < 0) ag = -ag;
      sq = longint'(s.accel_x) * longint'(s.accel_x) + longint'(s.accel_y) * longint'(s.accel_y)
         + longint'(s.accel_z) * longint'(s.accel_z);
      return (ap <= int'(regs.upright_window)) && (ag <= int'(regs.gyro_max))
          && (sq >= longint'(regs.accel_min_sq)) && (sq <= longint'(regs.accel_max_sq));
    endfunction

    function void note_sample(sample_t s);
      calib_result_t r;
      longint        pq;
      longint        nf;
      longint        err;
      bit            ok;
      bit            done;
      ok   = 0;
      done = 0;
      if (s.func) begin
        clear_all();
      end else begin
        ok = usable(s);
        // Once the midpoint is latched, samples are only classified.
        if (!ready) begin
          if (!ok) begin
            if (bad_run < INVALID_LIMIT) bad_run = bad_run + 3'd1;
            if (bad_run >= INVALID_LIMIT) drop_candidate();
          end else if (!started) begin
            bad_run = '0;
            filt    = int'(s.pitch) <<< 16;
            count   = 16'd1;
            started = 1;
            win_lo  = int'(s.pitch);
            win_hi  = int'(s.pitch);
          end else begin
            bad_run = '0;
            if (int'(s.pitch) < win_lo) win_lo = int'(s.pitch);
            if (int'(s.pitch) > win_hi) win_hi = int'(s.pitch);
            if (win_hi - win_lo > int'(regs.max_span)) begin
              drop_candidate();
            end else begin
              pq  = longint'(s.pitch) * 65536;
              nf  = longint'(filt)
                  + div_round(longint'(regs.filter_alpha) * (pq - longint'(filt)));
              err = pq - nf;
              if (err < 0) err = -err;
              if (err > longint'(regs.max_error) * 65536) begin
                drop_candidate();
              end else begin
                filt = int'(nf);
                if (count < regs.stable_target) count = count + 16'd1;
                if (count >= regs.stable_target) begin
                  mid   = angle_of(filt);
                  ready = 1;
                  done  = 1;
                end
              end
            end
          end
        end
      end
      r.ready    = ready;
      r.done     = done;
      r.midpoint = mid;
      r.angle    = angle_of(filt);
      r.count    = count;
      r.usable   = ok;
      expected_q.push_back(r);
    endfunction

    function void check_result(calib_result_t got);
      calib_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing expected: ready=%0b done=%0b mid=%0d",
                   checked, got.ready, got.done, got.midpoint);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.ready !== want.ready || got.done !== want.done || got.midpoint !== want.midpoint
          || got.angle !== want.angle || got.count !== want.count
          || got.usable !== want.usable) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: expected ready=%0b done=%0b mid=%0d angle=%0d count=%0d valid=%0b",
                   checked, want.ready, want.done, want.midpoint, want.angle, want.count,
                   want.usable);
          $display("result %0d: got      ready=%0b done=%0b mid=%0d angle=%0d count=%0d valid=%0b",
                   checked, got.ready, got.done, got.midpoint, got.angle, got.count, got.usable);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic signed [15:0] in_pitch = '0;
  logic signed [15:0] in_gyro_y = '0;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_ready_res;
  logic               out_just_completed;
  logic signed [15:0] out_midpoint;
  logic signed [15:0] out_filtered_angle;
  logic [15:0]        out_stable_count;
  logic               out_sample_valid;

  calib_scoreboard sb;
  cfg_t            cur;
  calib_result_t   seen;
  int              quiet_cycles = 0;
  int              sent = 0;
  int              burst_left = 0;
  bit              valid_up = 0;
  int              stall_mode = 0;
  int              stall_left = 0;

  tilt_midpoint_calibrator_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sample_t mk(bit f, int p, int g, int ax, int ay, int az);
    sample_t s;
    s.func    = f;
    s.pitch   = 16'(p);
    s.gyro_y  = 16'(g);
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    return s;
  endfunction

  // A still, upright sample for the directed part.
  function automatic sample_t calm(int p);
    return mk(1'b0, p, 0, 0, 0, 16384);
  endfunction

  function automatic sample_t noise();
    sample_t s;
    s.func    = ($urandom_range(15, 0) == 0);
    s.pitch   = 16'($urandom);
    s.gyro_y  = 16'($urandom);
    s.accel_x = 16'($urandom);
    s.accel_y = 16'($urandom);
    s.accel_z = 16'($urandom);
    return s;
  endfunction

  // A sample that should pass all three checks under the current settings, with its
  // pitch spread around the given centre.
  function automatic sample_t settled(int centre, int jit);
    int     w;
    int     p;
    int     lim;
    int     c;
    longint v;
    w   = int'(cur.upright_window);
    p   = centre - jit + int'($urandom_range(2 * jit, 0));
    if (p > w) p = w;
    if (p < -w) p = -w;
    lim = int'(cur.gyro_max);
    if (lim > 32767) lim = 32767;
    if (cur.accel_min_sq <= cur.accel_max_sq) begin
      v = longint'(cur.accel_min_sq)
        + longint'($urandom_range(cur.accel_max_sq - cur.accel_min_sq, 0));
    end else begin
      v = longint'(cur.accel_min_sq);
    end
    c = $rtoi($sqrt(real'(v) / 3.0));
    if (c > 32767) c = 32767;
    return mk(1'b0, p, int'($urandom_range(2 * lim, 0)) - lim,
              ($urandom_range(1, 0) != 0) ? c : -c, ($urandom_range(1, 0) != 0) ? c : -c,
              ($urandom_range(1, 0) != 0) ? c : -c);
  endfunction

  function automatic cfg_t phase_cfg(int ph);
    cfg_t c;
    c = RESET_CFG;
    case (ph)
      0: c.stable_target = 16'd20;
      1: c = '{filter_alpha: 16'hffff, upright_window: 15'd23040, gyro_max: 16'h8000,
               accel_min_sq: 32'd0, accel_max_sq: 32'd3221225472, max_span: 16'd46080,
               max_error: 16'd46080, stable_target: 16'd1};
      2: c = '{filter_alpha: 16'd1, upright_window: 15'd0, gyro_max: 16'd0,
               accel_min_sq: 32'd0, accel_max_sq: 32'd0, max_span: 16'd0,
               max_error: 16'd0, stable_target: 16'hffff};
      3: c = '{filter_alpha: 16'd0, upright_window: 15'h7fff, gyro_max: 16'hffff,
               accel_min_sq: 32'd0, accel_max_sq: 32'hffff_ffff, max_span: 16'd300,
               max_error: 16'd200, stable_target: 16'd0};
      4: c = '{filter_alpha: 16'd40000, upright_window: 15'd4000, gyro_max: 16'd500,
               accel_min_sq: 32'd100000000, accel_max_sq: 32'd500000000, max_span: 16'd60,
               max_error: 16'd30, stable_target: 16'd8};
      default: ;
    endcase
    return c;
  endfunction

  task automatic send(sample_t s);
    int gap;
    in_valid   <= 1'b1;
    in_func    <= s.func;
    in_pitch   <= s.pitch;
    in_gyro_y  <= s.gyro_y;
    in_accel_x <= s.accel_x;
    in_accel_y <= s.accel_y;
    in_accel_z <= s.accel_z;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(250, 100)
                                               : $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if ($urandom_range(15, 0) == 0) gap = 24;
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Every item yields a result, so an empty store means the pipeline is drained.
  task automatic wait_idle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    wait_idle();
    write_reg(CFG_FILTER_ALPHA, 32'(c.filter_alpha));
    write_reg(CFG_UPRIGHT_WINDOW, 32'(c.upright_window));
    write_reg(CFG_GYRO_MAX, 32'(c.gyro_max));
    write_reg(CFG_ACCEL_MIN_SQ, c.accel_min_sq);
    write_reg(CFG_ACCEL_MAX_SQ, c.accel_max_sq);
    write_reg(CFG_MAX_SPAN, 32'(c.max_span));
    write_reg(CFG_MAX_ERROR, 32'(c.max_error));
    write_reg(CFG_STABLE_TARGET, 32'(c.stable_target));
    cfg_we <= 1'b0;
    sb.load_config(c);
    cur = c;
  endtask

  // One candidate: a stretch of still samples around a centre, sprinkled with junk.
  task automatic calm_run();
    sample_t s;
    int      centre;
    int      jit;
    int      len;
    int      w;
    w      = int'(cur.upright_window);
    centre = int'($urandom_range(2 * w, 0)) - w;
    case ($urandom_range(3, 0))
      0: jit = 0;
      1: jit = $urandom_range(3, 0);
      2: jit = $urandom_range(int'(cur.max_span) / 2 + 1, 0);
      default: jit = $urandom_range(int'(cur.max_span) + int'(cur.max_error) + 8, 0);
    endcase
    if (jit > 20000) jit = 20000;
    len = int'(cur.stable_target) + 8;
    if (len > 350) len = 350;
    len = $urandom_range(len, 1);
    repeat (len) begin
      if ($urandom_range(11, 0) == 0) begin
        s = noise();
        s.func = 1'b0;
      end else begin
        s = settled(centre, jit);
      end
      send(s);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(4, 0);
      stall_left = $urandom_range(150, 10);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      2: out_stall <= ($urandom_range(1, 0) == 0);
      3: out_stall <= ((stall_left % 7) < 3);
      default: out_stall <= ($urandom_range(9, 0) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(mk(in_func, in_pitch, in_gyro_y, in_accel_x, in_accel_y, in_accel_z));
      end
      if (out_valid && !out_stall) begin
        seen.ready    = out_ready_res;
        seen.done     = out_just_completed;
        seen.midpoint = out_midpoint;
        seen.angle    = out_filtered_angle;
        seen.count    = out_stable_count;
        seen.usable   = out_sample_valid;
        sb.check_result(seen);
      end
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0
                                                                              : quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    cfg_t dcfg;
    int   target_items;
    int   pick;
    sb = new;
    sb.clear_all();
    sb.load_config(RESET_CFG);
    cur = RESET_CFG;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Check boundaries under the reset settings, then six unusable items in a row.
    send(mk(1'b1, 32767, -32768, 0, 0, 0));
    send(mk(1'b0, 1536, 32, 0, 0, 13927));
    send(mk(1'b0, -1537, 0, 0, 0, 16384));
    send(mk(1'b0, 0, -33, 0, 0, 16384));
    send(mk(1'b0, 0, 0, 0, 0, 13926));
    send(mk(1'b0, 0, 0, 0, 0, 18842));
    send(mk(1'b0, -32768, -32768, -32768, -32768, -32768));
    send(mk(1'b0, 32767, 32767, 32767, 32767, 32767));
    send(mk(1'b0, -1536, -32, 0, 0, -18841));

    dcfg = RESET_CFG;
    dcfg.filter_alpha  = 16'h8000;
    dcfg.max_span      = 16'd300;
    dcfg.stable_target = 16'd3;
    apply_config(dcfg);
    // Latch, then a sample once ready.
    send(calm(100));
    send(calm(110));
    send(calm(105));
    send(calm(3));
    send(mk(1'b1, 0, 0, 0, 0, 0));
    // Filter lands on exactly one half, above and below zero.
    send(calm(0));
    send(calm(1));
    send(mk(1'b1, 0, 0, 0, 0, 0));
    send(calm(0));
    send(calm(-1));
    send(mk(1'b1, 0, 0, 0, 0, 0));
    // Error too large, then window too wide.
    send(calm(0));
    send(calm(200));
    send(calm(0));
    send(calm(400));

    for (int ph = 0; ph < 6; ph++) begin
      apply_config(phase_cfg(ph));
      target_items = sent + PHASE_ITEMS[ph];
      while (sent < target_items) begin
        pick = $urandom_range(9, 0);
        if (pick < 7) begin
          calm_run();
          if ($urandom_range(1, 0) == 0) send(mk(1'b1, 0, 0, 0, 0, 0));
        end else if (pick == 7) begin
          send(mk(1'b1, int'(16'($urandom)), 0, 0, 0, 0));
        end else begin
          repeat ($urandom_range(8, 1)) send(noise());
        end
      end
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tmc_pkg.sv
hw/rtl/tmc_front.sv
hw/rtl/tmc_queue.sv
hw/rtl/tmc_back.sv
hw/rtl/tilt_midpoint_calibrator_core.sv
hw/rtl/tmc_checker.sv
bench/tilt_midpoint_calibrator_core_tb.sv
